// ----- design/priority_run_queue_scheduler_top_assert.svh -----
// Assertion macros for the run queue scheduler.
// Used by the top level; empty bodies when SYNTHESIS is defined.
`ifndef PRIORITY_RUN_QUEUE_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_RUN_QUEUE_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PRQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PRQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PRQ_ASSERT(lbl, clk, rstn, prop, msg)
`define PRQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ----- design/prqs_pkg.sv -----
// Package for the run queue scheduler: constants, codes and types.
// No dependencies.
`default_nettype none
package prqs_pkg;
  localparam int unsigned QueueDepth   = 16;
  localparam int unsigned ThreadIdBits = 8;
  localparam int unsigned PriorityBits = 16;

  localparam logic [2:0] ModeEnqueue  = 3'd0;
  localparam logic [2:0] ModeRemove   = 3'd1;
  localparam logic [2:0] ModeSetReady = 3'd2;
  localparam logic [2:0] ModeSchedule = 3'd3;
  localparam logic [2:0] ModeSetPrio  = 3'd4;

  localparam logic [2:0] StatusOk      = 3'd0;
  localparam logic [2:0] StatusQueued  = 3'd1;
  localparam logic [2:0] StatusAbsent  = 3'd2;
  localparam logic [2:0] StatusFull    = 3'd3;
  localparam logic [2:0] StatusBadPrio = 3'd4;

  localparam logic [1:0] RegAgeingShift = 2'd0;
  localparam logic [1:0] RegIdleThread  = 2'd1;
  localparam logic [1:0] RegMaxPriority = 2'd2;

  typedef enum logic [3:0] {
    StIdle, StFind, StReq1, StIns, StSearch, StReq2, StFind2, StRemove, StDone
  } state_e;

  typedef enum logic [1:0] {
    OpHold, OpShiftUp, OpShiftDown
  } shift_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] thread_id;
    logic [15:0] priority_req;
    logic        insert_first;
    logic [31:0] last_run_ms;
    logic [31:0] now_ms;
    logic        ready_flag;
  } req_t;

  typedef struct packed {
    logic [7:0] next_thread_id;
    logic       found;
    logic [2:0] status;
    logic [4:0] queue_count;
  } rsp_t;
endpackage
`default_nettype wire

// ----- design/prqs_stream_if.sv -----
// Valid/ready channel interface carrying one item.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface prqs_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/priority_run_queue_scheduler_top.sv -----
// Top level of the run queue scheduler: APB registers, control sequencer and
// a chain of queue cells. Depends on prqs_pkg, prqs_stream_if and prqs_cell.
// Each item is handled by a sequencer that walks the chain of cells one slot
// per cycle, reading one entry at a time. The shortest items are an undefined
// mode and a request against an empty queue; the longest is a schedule that
// requeues the running thread into a full queue and then removes the chosen
// entry. The number of linear passes over the queue sets how long an item
// takes: up to three lookups, one insertion walk and one search. One item is
// worked on at a time. The result register lets the next item be accepted
// while the last result waits; a finished item holds in its last step until
// that register is free.
`default_nettype none
`include "priority_run_queue_scheduler_top_assert.svh"
module priority_run_queue_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = prqs_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  prqs_stream_if.sink     req_if,
  prqs_stream_if.source   rsp_if,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import prqs_pkg::*;
  localparam int unsigned TW = ThreadIdBits;
  localparam int unsigned PW = PriorityBits;
  localparam int unsigned EW = TW + PW + 33;
  localparam int unsigned SL = QUEUE_DEPTH + 1;
  localparam int unsigned IW = $clog2(SL + 1);

  logic [4:0]  age_q;
  logic [7:0]  idle_q;
  logic [15:0] maxp_q;
  logic        wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= 5'd7; idle_q <= 8'd2; maxp_q <= 16'd4096;
    end else if (wr) begin
      case (paddr[3:2])
        RegAgeingShift: age_q <= pwdata[4:0];
        RegIdleThread:  idle_q <= pwdata[7:0];
        RegMaxPriority: maxp_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      RegAgeingShift: prdata = {27'd0, age_q};
      RegIdleThread:  prdata = {24'd0, idle_q};
      RegMaxPriority: prdata = {16'd0, maxp_q};
      default:        prdata = 32'd0;
    endcase
  end

  // Cell chain.
  shift_e            op;
  logic [SL-1:0]     ld;
  logic [TW-1:0]     ld_tid;
  logic [PW-1:0]     ld_prio;
  logic [31:0]       ld_last;
  logic              ld_rdy;
  logic [EW-1:0]     ent [SL];
  logic [EW-1:0]     prv [SL];
  logic [EW-1:0]     nxt [SL];
  logic [IW-1:0]     lo_q, lo_d;
  // Cells below lo hold; cells at or above lo shift.
  for (genvar g = 0; g < SL; g++) begin : g_cell
    shift_e cop;
    assign prv[g] = (g == 0) ? ent[0] : ent[(g == 0) ? 0 : g-1];
    assign nxt[g] = (g == SL-1) ? ent[g] : ent[(g == SL-1) ? g : g+1];
    assign cop = (IW'(g) >= lo_q) ? op : OpHold;
    prqs_cell #(.TidW(TW), .PrW(PW)) u_cell (
      .clk_i, .op_i(cop), .load_i(ld[g]), .ld_tid_i(ld_tid), .ld_prio_i(ld_prio),
      .ld_last_i(ld_last), .ld_rdy_i(ld_rdy), .prev_i(prv[g]), .next_i(nxt[g]),
      .ent_o(ent[g]));
  end

  state_e      st_q, st_d;
  req_t        rq_q, rq_d;
  logic [IW-1:0] cnt_q, cnt_d, ix_q, ix_d, hit_q, hit_d;
  logic        hv_q, hv_d;
  logic [TW-1:0] cur_q, cur_d, nx_q, nx_d;
  logic [PW-1:0] cpr_q, cpr_d, bp_q, bp_d;
  logic [31:0]   clr_q, clr_d;
  logic        have_q, have_d;
  logic [2:0]  stat_q, stat_d;
  logic        ins_front_q, ins_front_d;
  logic [1:0]  phase_q, phase_d;
  logic        rv_q, rv_d;
  rsp_t        rs_q, rs_d;
  logic [TW-1:0] ftid;
  logic [TW-1:0] etid;
  logic [PW-1:0] epr;
  logic [31:0]   elr;
  logic          erd;
  logic [IW-1:0] ixs;
  logic [31:0]   kk;
  logic [PW-1:0] aged;
  logic [PW-1:0] ins_prio;
  logic          gofront;
  logic [TW-1:0] tid;

  assign ixs = (ix_q < IW'(SL)) ? ix_q : '0;
  assign {etid, epr, elr, erd} = ent[ixs[IW-1:0]];
  assign tid = rq_q.thread_id[TW-1:0];
  assign kk = (rq_q.now_ms - elr) >> age_q;
  always_comb begin
    if (epr >= PW'(maxp_q) && {16'd0, epr} >= {16'd0, maxp_q}) aged = epr;
    else if (kk >= 32'(PW)) aged = '0;
    else aged = epr >> kk[4:0];
  end
  assign ins_prio = (phase_q != 2'd0) ? cpr_q : rq_q.priority_req[PW-1:0];
  assign gofront = ins_front_q ? (epr >= ins_prio) : (epr > ins_prio);

  always_comb begin
    st_d = st_q; rq_d = rq_q; cnt_d = cnt_q; ix_d = ix_q; hit_d = hit_q;
    hv_d = hv_q; cur_d = cur_q; nx_d = nx_q; cpr_d = cpr_q; bp_d = bp_q;
    clr_d = clr_q; have_d = have_q; stat_d = stat_q; ins_front_d = ins_front_q;
    phase_d = phase_q; rv_d = rv_q; rs_d = rs_q; lo_d = lo_q;
    op = OpHold; ld = '0; ld_tid = tid; ld_prio = rq_q.priority_req[PW-1:0];
    ld_last = rq_q.last_run_ms; ld_rdy = 1'b1;
    ftid = tid;
    if (rsp_if.ready) rv_d = 1'b0;
    if (phase_q != 2'd0) begin
      ld_tid = cur_q; ld_prio = cpr_q; ld_last = clr_q;
    end
    if (st_q == StFind2) ftid = nx_q;
    if (st_q == StFind && phase_q != 2'd0) ftid = cur_q;
    case (st_q)
      StIdle: begin
        if (req_if.valid) begin
          rq_d = req_if.data; st_d = StFind; ix_d = '0; hv_d = 1'b0;
          stat_d = StatusOk; have_d = 1'b0; phase_d = 2'd0;
        end
      end
      StFind: begin
        if (ix_q < cnt_q && !hv_q) begin
          if (etid == ftid) begin hv_d = 1'b1; hit_d = ix_q; end
          else ix_d = ix_q + IW'(1);
        end else begin
          st_d = StReq1;
        end
      end
      StReq1: begin
        st_d = StDone;
        ix_d = '0;
        if (phase_q == 2'd1) begin
          if (hv_q) st_d = StSearch;
          else begin st_d = StIns; ins_front_d = 1'b1; end
        end else if (phase_q == 2'd2) begin
          if (!hv_q) begin st_d = StIns; ins_front_d = 1'b0; end
          else st_d = StReq2;
        end else begin
          case (rq_q.mode)
            ModeEnqueue: begin
              if (hv_q) stat_d = StatusQueued;
              else if (cnt_q >= IW'(QUEUE_DEPTH)) stat_d = StatusFull;
              else begin st_d = StIns; ins_front_d = rq_q.insert_first; end
            end
            ModeRemove: begin
              if (!hv_q) stat_d = StatusAbsent;
              else begin st_d = StRemove; lo_d = hit_q; end
            end
            ModeSetReady: begin
              if (!hv_q) stat_d = StatusAbsent;
              else begin
                ix_d = hit_q; ld[hit_q] = 1'b1;
                {ld_tid, ld_prio, ld_last} = {etid, epr, elr};
                ix_d = hit_q;
                st_d = StReq2; phase_d = 2'd3;
              end
            end
            ModeSchedule: begin
              if (rq_q.ready_flag && rq_q.insert_first) begin
                phase_d = 2'd1; st_d = StFind; hv_d = 1'b0;
              end else st_d = StSearch;
            end
            ModeSetPrio: begin
              if (rq_q.priority_req > maxp_q) stat_d = StatusBadPrio;
              else begin
                if (tid == cur_q) cpr_d = rq_q.priority_req[PW-1:0];
                if (hv_q) begin ix_d = hit_q; st_d = StReq2; phase_d = 2'd3; end
                else if (tid != cur_q) stat_d = StatusAbsent;
              end
            end
            default: ;
          endcase
        end
      end
      StIns: begin
        if (ix_q < cnt_q && !gofront) ix_d = ix_q + IW'(1);
        else begin
          lo_d = ix_q; op = OpHold; st_d = StRemove; phase_d = phase_q;
          if (lo_q == ix_q) begin
            op = OpShiftUp; ld[ixs] = 1'b1;
            cnt_d = cnt_q + IW'(1);
            st_d = (phase_q == 2'd1) ? StSearch : (phase_q == 2'd2) ? StReq2 : StDone;
            ix_d = '0;
          end else st_d = StIns;
        end
      end
      StSearch: begin
        if (ix_q < cnt_q) begin
          if (erd && (!have_q || aged < bp_q)) begin
            have_d = 1'b1; bp_d = aged; nx_d = etid;
          end
          ix_d = ix_q + IW'(1);
        end else begin
          ix_d = '0;
          if (rq_q.ready_flag && !rq_q.insert_first) begin
            phase_d = 2'd2; st_d = StFind; hv_d = 1'b0;
          end else st_d = StReq2;
          if (!have_q) st_d = (rq_q.ready_flag && !rq_q.insert_first) ? StFind : StDone;
        end
      end
      StReq2: begin
        if (phase_q == 2'd3) begin
          ld[ixs] = 1'b1;
          {ld_tid, ld_prio, ld_last, ld_rdy} = {etid, epr, elr, erd};
          if (rq_q.mode == ModeSetReady) ld_rdy = rq_q.ready_flag;
          else ld_prio = rq_q.priority_req[PW-1:0];
          st_d = StDone;
        end else begin
          if (phase_q == 2'd2 && (!have_q || nx_q == idle_q[TW-1:0])) begin
            have_d = 1'b1; nx_d = cur_q;
          end
          hv_d = 1'b0; ix_d = '0; st_d = StFind2;
        end
      end
      StFind2: begin
        if (ix_q < cnt_q && !hv_q) begin
          if (etid == ftid) begin hv_d = 1'b1; hit_d = ix_q; end
          else ix_d = ix_q + IW'(1);
        end else begin
          cur_d = nx_q; clr_d = rq_q.now_ms; stat_d = StatusOk;
          if (hv_q) begin cpr_d = epr; lo_d = hit_q; st_d = StRemove; ix_d = hit_q; end
          else st_d = StDone;
          have_d = 1'b1;
        end
      end
      StRemove: begin
        if (rq_q.mode == ModeRemove || rq_q.mode == ModeSchedule) begin
          op = OpShiftDown; cnt_d = cnt_q - IW'(1);
        end
        st_d = StDone;
      end
      StDone: begin
        if (!rv_q || rsp_if.ready) begin
          rs_d.next_thread_id = 8'(cur_q);
          rs_d.found = (rq_q.mode == ModeSchedule) && have_q;
          rs_d.status = stat_q;
          rs_d.queue_count = 5'(cnt_q);
          rv_d = 1'b1; st_d = StIdle; lo_d = '0;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; cur_q <= TW'(1); cpr_q <= '0; clr_q <= '0;
      rv_q <= 1'b0; lo_q <= '0; phase_q <= '0; hv_q <= 1'b0; have_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; cur_q <= cur_d; cpr_q <= cpr_d; clr_q <= clr_d;
      rv_q <= rv_d; lo_q <= lo_d; phase_q <= phase_d; hv_q <= hv_d; have_q <= have_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rq_q <= rq_d; ix_q <= ix_d; hit_q <= hit_d; nx_q <= nx_d; bp_q <= bp_d;
    stat_q <= stat_d; ins_front_q <= ins_front_d; rs_q <= rs_d;
  end

  assign req_if.ready = (st_q == StIdle);
  assign rsp_if.valid = rv_q;
  assign rsp_if.data  = rs_q;

  `PRQ_ASSERT(a_cnt_max, clk_i, rst_ni, (st_q == StIdle) |-> (cnt_q <= IW'(QUEUE_DEPTH)), "queue over depth")
  `PRQ_ASSERT(a_done_valid, clk_i, rst_ni, (st_q == StDone) |=> rv_q, "result not posted")
  `PRQ_ASSERT(a_rsp_stable, clk_i, rst_ni, (rsp_if.valid && !rsp_if.ready) |=> (rsp_if.valid && $stable(rsp_if.data)), "result changed")
  `PRQ_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, req_if.ready && (st_q != StIdle), "ready while busy")
endmodule
`default_nettype wire

// ----- design/prqs_cell.sv -----
// One queue slot: holds an entry and shifts toward either neighbor.
// Depends on prqs_pkg.
`default_nettype none
module prqs_cell #(
  parameter int unsigned TidW = 8,
  parameter int unsigned PrW  = 16
) (
  input  wire logic           clk_i,
  input  prqs_pkg::shift_e    op_i,
  input  wire logic           load_i,
  input  wire logic [TidW-1:0] ld_tid_i,
  input  wire logic [PrW-1:0]  ld_prio_i,
  input  wire logic [31:0]     ld_last_i,
  input  wire logic            ld_rdy_i,
  input  wire logic [TidW+PrW+32:0] prev_i,
  input  wire logic [TidW+PrW+32:0] next_i,
  output logic [TidW+PrW+32:0] ent_o
);
  import prqs_pkg::*;
  logic [TidW+PrW+32:0] ent_q, ent_d;
  always_comb begin
    ent_d = ent_q;
    case (op_i)
      OpShiftUp:   ent_d = prev_i;
      OpShiftDown: ent_d = next_i;
      default:     ent_d = ent_q;
    endcase
    if (load_i) begin
      ent_d = {ld_tid_i, ld_prio_i, ld_last_i, ld_rdy_i};
    end
  end
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end
  assign ent_o = ent_q;
endmodule
`default_nettype wire
